@@ hw/rtl/qau_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qau_pkg: shared codes for the quaternion arithmetic unit
// Operation codes carried on the op port and the result status codes.
// ----------------------------------------------------------------------------
package qau_pkg;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_CONJ = 4'd3,
		OP_SCALE = 4'd4,
		OP_DOT  = 4'd5,
		OP_LEN  = 4'd6,
		OP_NORM = 4'd7,
		OP_INV  = 4'd8
	} op_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SAT   = 2'd1;
	localparam logic [1:0] ST_IDENT = 2'd2;

endpackage
`default_nettype wire

@@ hw/rtl/quaternion_arithmetic_unit.sv @@
// Throughput: one item per cycle unless the output stalls; the depth is set by the
// bit-serial square root (COMP_WIDTH + 1 stages) and the four restoring divider
// lanes (FRAC_BITS + 1 stages). A one-entry skid register at the output catches a
// result that is not taken, so input transfers halt only once it is full.
// Reset (arst_n low) empties all stages and the skid register.
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit: pipelined Q-format quaternion ALU
// Add, subtract, Hamilton product, conjugate, scale, dot, length, normalize and
// inverse, with saturation and a status code per result.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit import qau_pkg::*; #(
	parameter int FRAC_BITS  = 12,
	parameter int COMP_WIDTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [3:0]                   op,
	input  wire logic signed [COMP_WIDTH-1:0] a_w,
	input  wire logic signed [COMP_WIDTH-1:0] a_x,
	input  wire logic signed [COMP_WIDTH-1:0] a_y,
	input  wire logic signed [COMP_WIDTH-1:0] a_z,
	input  wire logic signed [COMP_WIDTH-1:0] b_w,
	input  wire logic signed [COMP_WIDTH-1:0] b_x,
	input  wire logic signed [COMP_WIDTH-1:0] b_y,
	input  wire logic signed [COMP_WIDTH-1:0] b_z,
	input  wire logic signed [COMP_WIDTH-1:0] scale_factor,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [COMP_WIDTH-1:0]      r_w,
	output logic signed [COMP_WIDTH-1:0]      r_x,
	output logic signed [COMP_WIDTH-1:0]      r_y,
	output logic signed [COMP_WIDTH-1:0]      r_z,
	output logic signed [31:0]                scalar_result,
	output logic [1:0]                        status
);

	localparam int W   = COMP_WIDTH;
	localparam int F   = FRAC_BITS;
	localparam int PW  = 2 * W;
	localparam int AW  = 2 * W + 3;
	localparam int SQW = 2 * W + 2;
	localparam int RW  = W + 1;
	localparam int QB  = F + 1;
	localparam int DW  = W + F + 3;
	localparam int XW  = 72;

	typedef struct packed {
		logic [3:0]          op;
		logic [3:0][W-1:0]   r;
		logic [31:0]         sc;
		logic                flag;
		logic [3:0][W-1:0]   mag;
		logic [3:0]          neg;
	} side_t;

	function automatic logic signed [XW-1:0] clip(input logic signed [XW-1:0] v,
		input int n);
		logic signed [XW-1:0] mx, mn, res;
		mx = (XW'(1) << (n - 1)) - XW'(1);
		mn = -mx - XW'(1);
		if (v > mx) res = mx;
		else if (v < mn) res = mn;
		else res = v;
		return res;
	endfunction

	function automatic logic ovf(input logic signed [XW-1:0] v, input int n);
		return clip(v, n) != v;
	endfunction

	function automatic logic signed [AW-1:0] rnd(input logic signed [AW-1:0] s);
		return (s + (AW'(1) <<< (F - 1))) >>> F;
	endfunction

	logic ce;
	logic skid_q;

	// The whole pipeline moves together; it halts only while the skid entry is taken.
	assign ce = !skid_q;
	assign in_ready = ce;

	// ---------------- Stage 1: products and simple component operations
	logic signed [W-1:0] a_in [4];
	logic signed [W-1:0] b_in [4];

	assign a_in[0] = a_w;
	assign a_in[1] = a_x;
	assign a_in[2] = a_y;
	assign a_in[3] = a_z;
	assign b_in[0] = b_w;
	assign b_in[1] = b_x;
	assign b_in[2] = b_y;
	assign b_in[3] = b_z;

	logic                v_s1;
	logic [3:0]          op_s1;
	logic signed [PW-1:0] hp_s1 [4][4];
	logic signed [PW-1:0] scp_s1 [4];
	logic signed [PW-1:0] sqp_s1 [4];
	logic signed [W:0]   as_s1 [4];
	logic signed [W:0]   cj_s1 [4];
	logic [W-1:0]        mag_s1 [4];
	logic [3:0]          neg_s1;

	always_ff @(posedge clk) begin
		if (ce) begin
			op_s1 <= op;
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					hp_s1[i][j] <= a_in[i] * b_in[j];
				end
				scp_s1[i] <= a_in[i] * scale_factor;
				sqp_s1[i] <= a_in[i] * a_in[i];
				as_s1[i] <= (op == OP_SUB) ? ((W+1)'(a_in[i]) - (W+1)'(b_in[i]))
					: ((W+1)'(a_in[i]) + (W+1)'(b_in[i]));
				cj_s1[i] <= (i == 0) ? (W+1)'(a_in[i]) : -(W+1)'(a_in[i]);
				mag_s1[i] <= a_in[i][W-1] ? W'(-a_in[i]) : W'(a_in[i]);
				// Inverse normalizes the conjugate, so the vector signs flip.
				neg_s1[i] <= (op == OP_INV && i != 0) ? (a_in[i] > 0) : a_in[i][W-1];
			end
		end
	end

	// ---------------- Stage 2: sums of products, each rounded once but the sum of squares
	logic                 v_s2;
	logic [3:0]           op_s2;
	logic signed [AW-1:0] ham_s2 [4];
	logic signed [AW-1:0] scl_s2 [4];
	logic signed [AW-1:0] dot_s2;
	logic [SQW-1:0]       sq_s2;
	logic signed [W:0]    as_s2 [4];
	logic signed [W:0]    cj_s2 [4];
	logic [W-1:0]         mag_s2 [4];
	logic [3:0]           neg_s2;

	always_ff @(posedge clk) begin
		if (ce) begin
			op_s2 <= op_s1;
			ham_s2[0] <= rnd(AW'(hp_s1[0][0]) - AW'(hp_s1[1][1])
				- AW'(hp_s1[2][2]) - AW'(hp_s1[3][3]));
			ham_s2[1] <= rnd(AW'(hp_s1[0][1]) + AW'(hp_s1[1][0])
				+ AW'(hp_s1[2][3]) - AW'(hp_s1[3][2]));
			ham_s2[2] <= rnd(AW'(hp_s1[0][2]) - AW'(hp_s1[1][3])
				+ AW'(hp_s1[2][0]) + AW'(hp_s1[3][1]));
			ham_s2[3] <= rnd(AW'(hp_s1[0][3]) + AW'(hp_s1[1][2])
				- AW'(hp_s1[2][1]) + AW'(hp_s1[3][0]));
			dot_s2 <= rnd(AW'(hp_s1[0][0]) + AW'(hp_s1[1][1])
				+ AW'(hp_s1[2][2]) + AW'(hp_s1[3][3]));
			sq_s2 <= SQW'($unsigned(sqp_s1[0])) + SQW'($unsigned(sqp_s1[1]))
				+ SQW'($unsigned(sqp_s1[2])) + SQW'($unsigned(sqp_s1[3]));
			for (int i = 0; i < 4; i++) begin
				scl_s2[i] <= rnd(AW'(scp_s1[i]));
				as_s2[i] <= as_s1[i];
				cj_s2[i] <= cj_s1[i];
				mag_s2[i] <= mag_s1[i];
			end
			neg_s2 <= neg_s1;
		end
	end

	// ---------------- Stage 3: per-operation selection and saturation
	side_t          sd_n3;
	logic [SQW-1:0] sumc_n3;
	logic           v_s3;
	side_t          sd_s3;
	logic [SQW-1:0] sumc_s3;

	always_comb begin
		sd_n3 = '0;
		sd_n3.op = op_s2;
		sd_n3.neg = neg_s2;
		for (int i = 0; i < 4; i++) begin
			sd_n3.mag[i] = mag_s2[i];
		end
		case (op_s2)
			OP_ADD, OP_SUB: begin
				for (int i = 0; i < 4; i++) begin
					sd_n3.r[i] = W'(clip(XW'(as_s2[i]), W));
					sd_n3.flag = sd_n3.flag | ovf(XW'(as_s2[i]), W);
				end
			end
			OP_MUL: begin
				for (int i = 0; i < 4; i++) begin
					sd_n3.r[i] = W'(clip(XW'(ham_s2[i]), W));
					sd_n3.flag = sd_n3.flag | ovf(XW'(ham_s2[i]), W);
				end
			end
			OP_CONJ: begin
				for (int i = 0; i < 4; i++) begin
					sd_n3.r[i] = W'(clip(XW'(cj_s2[i]), W));
					sd_n3.flag = sd_n3.flag | ovf(XW'(cj_s2[i]), W);
				end
			end
			OP_SCALE: begin
				for (int i = 0; i < 4; i++) begin
					sd_n3.r[i] = W'(clip(XW'(scl_s2[i]), W));
					sd_n3.flag = sd_n3.flag | ovf(XW'(scl_s2[i]), W);
				end
			end
			OP_DOT: begin
				sd_n3.sc = 32'(clip(XW'(dot_s2), 32));
				sd_n3.flag = ovf(XW'(dot_s2), 32);
			end
			default: begin
			end
		endcase
		// A sum of squares beyond 64 bits counts as the largest 64-bit value.
		sumc_n3 = (|(sq_s2 >> 64)) ? SQW'(64'hFFFF_FFFF_FFFF_FFFF) : sq_s2;
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sd_s3 <= sd_n3;
			sumc_s3 <= sumc_n3;
		end
	end

	// ---------------- Stage group 4: square root, one result bit per stage
	logic [RW-1:0]  v_s4;
	logic [SQW-1:0] x_s4 [RW];
	logic [SQW-1:0] r_s4 [RW];
	side_t          sd_s4 [RW];

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		logic [SQW-1:0] x_in;
		logic [SQW-1:0] r_in;
		logic [SQW-1:0] one_k;
		logic [SQW-1:0] trial;
		side_t          sd_in;
		logic           v_in;

		if (k == 0) begin : g_first
			assign x_in = sumc_s3;
			assign r_in = '0;
			assign sd_in = sd_s3;
			assign v_in = v_s3;
		end else begin : g_next
			assign x_in = x_s4[k-1];
			assign r_in = r_s4[k-1];
			assign sd_in = sd_s4[k-1];
			assign v_in = v_s4[k-1];
		end

		assign one_k = SQW'(1) << (2 * (RW - 1 - k));
		assign trial = r_in + one_k;

		always_ff @(posedge clk) begin
			if (ce) begin
				if (x_in >= trial) begin
					x_s4[k] <= x_in - trial;
					r_s4[k] <= (r_in >> 1) + one_k;
				end else begin
					x_s4[k] <= x_in;
					r_s4[k] <= r_in >> 1;
				end
				sd_s4[k] <= sd_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s4[k] <= 1'b0;
			end else if (ce) begin
				v_s4[k] <= v_in;
			end
		end
	end

	// ---------------- Stage 5: length result and divider setup
	logic [RW-1:0]  len_n5;
	side_t          sd_n5;
	logic           v_s5;
	side_t          sd_s5;
	logic           zero_s5;
	logic [DW-1:0]  dvs_s5;
	logic [DW-1:0]  rem_s5 [4];

	assign len_n5 = r_s4[RW-1][RW-1:0];

	always_comb begin
		sd_n5 = sd_s4[RW-1];
		if (sd_s4[RW-1].op == OP_LEN) begin
			if (64'(len_n5) > 64'h7FFF_FFFF) begin
				sd_n5.sc = 32'h7FFF_FFFF;
				sd_n5.flag = 1'b1;
			end else begin
				sd_n5.sc = 32'(len_n5);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			sd_s5 <= sd_n5;
			zero_s5 <= (len_n5 == '0);
			dvs_s5 <= DW'(len_n5) << 1;
			// Rounded quotient: floor((2*num + len) / (2*len)).
			for (int i = 0; i < 4; i++) begin
				rem_s5[i] <= (DW'(sd_s4[RW-1].mag[i]) << (F + 1)) + DW'(len_n5);
			end
		end
	end

	// ---------------- Stage group 6: four restoring divider lanes
	logic [QB-1:0] v_s6;
	side_t         sd_s6 [QB];
	logic          zero_s6 [QB];
	logic [DW-1:0] dvs_s6 [QB];
	logic [DW-1:0] rem_s6 [QB][4];
	logic [QB-1:0] q_s6 [QB][4];

	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [DW-1:0] rem_in [4];
		logic [QB-1:0] q_in [4];
		logic [DW-1:0] dvs_in;
		logic [DW-1:0] cmp;
		side_t         sd_in;
		logic          zero_in;
		logic          v_in;

		if (k == 0) begin : g_first
			assign dvs_in = dvs_s5;
			assign sd_in = sd_s5;
			assign zero_in = zero_s5;
			assign v_in = v_s5;
			for (genvar i = 0; i < 4; i++) begin : g_lane
				assign rem_in[i] = rem_s5[i];
				assign q_in[i] = '0;
			end
		end else begin : g_next
			assign dvs_in = dvs_s6[k-1];
			assign sd_in = sd_s6[k-1];
			assign zero_in = zero_s6[k-1];
			assign v_in = v_s6[k-1];
			for (genvar i = 0; i < 4; i++) begin : g_lane
				assign rem_in[i] = rem_s6[k-1][i];
				assign q_in[i] = q_s6[k-1][i];
			end
		end

		assign cmp = dvs_in << (QB - 1 - k);

		always_ff @(posedge clk) begin
			if (ce) begin
				for (int i = 0; i < 4; i++) begin
					if (rem_in[i] >= cmp) begin
						rem_s6[k][i] <= rem_in[i] - cmp;
						q_s6[k][i] <= q_in[i] | (QB'(1) << (QB - 1 - k));
					end else begin
						rem_s6[k][i] <= rem_in[i];
						q_s6[k][i] <= q_in[i];
					end
				end
				dvs_s6[k] <= dvs_in;
				sd_s6[k] <= sd_in;
				zero_s6[k] <= zero_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s6[k] <= 1'b0;
			end else if (ce) begin
				v_s6[k] <= v_in;
			end
		end
	end

	// ---------------- Stage 7: signs, saturation, status (output register)
	side_t                sd_l;
	logic [3:0][W-1:0]    r_n7;
	logic [1:0]           st_n7;
	logic signed [XW-1:0] qv;
	logic                 nflag;

	assign sd_l = sd_s6[QB-1];

	always_comb begin
		r_n7 = sd_l.r;
		st_n7 = sd_l.flag ? ST_SAT : ST_OK;
		nflag = 1'b0;
		qv = '0;
		if (sd_l.op inside {OP_NORM, OP_INV}) begin
			if (zero_s6[QB-1]) begin
				r_n7 = '0;
				r_n7[0] = W'(clip(XW'(1) << F, W));
				st_n7 = ST_IDENT;
			end else begin
				for (int i = 0; i < 4; i++) begin
					qv = XW'(q_s6[QB-1][i]);
					if (sd_l.neg[i]) qv = -qv;
					r_n7[i] = W'(clip(qv, W));
					nflag = nflag | ovf(qv, W);
				end
				st_n7 = nflag ? ST_SAT : ST_OK;
			end
		end
	end

	logic                v_s7;
	logic [3:0][W-1:0]   r_s7;
	logic [31:0]         sc_s7;
	logic [1:0]          st_s7;

	always_ff @(posedge clk) begin
		if (ce) begin
			r_s7 <= r_n7;
			sc_s7 <= sd_l.sc;
			st_s7 <= st_n7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (ce) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s5 <= v_s4[RW-1];
			v_s7 <= v_s6[QB-1];
		end
	end

	// ---------------- Output skid register
	logic [3:0][W-1:0] r_q;
	logic [31:0]       sc_q;
	logic [1:0]        st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_q <= 1'b0;
		end else if (skid_q) begin
			if (out_ready) skid_q <= 1'b0;
		end else if (v_s7 && !out_ready) begin
			skid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_q) begin
			r_q <= r_s7;
			sc_q <= sc_s7;
			st_q <= st_s7;
		end
	end

	assign out_valid = skid_q | v_s7;
	assign r_w = skid_q ? r_q[0] : r_s7[0];
	assign r_x = skid_q ? r_q[1] : r_s7[1];
	assign r_y = skid_q ? r_q[2] : r_s7[2];
	assign r_z = skid_q ? r_q[3] : r_s7[3];
	assign scalar_result = skid_q ? sc_q : sc_s7;
	assign status = skid_q ? st_q : st_s7;

endmodule
`default_nettype wire

@@ hw/rtl/qau_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// qau_checker: port-level checks for the quaternion arithmetic unit
// Watches the result channel and the relation between its fields.
// ----------------------------------------------------------------------------
module qau_checker import qau_pkg::*; #(
	parameter int COMP_WIDTH = 16
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_ready,
	input wire logic signed [COMP_WIDTH-1:0] r_w,
	input wire logic signed [COMP_WIDTH-1:0] r_x,
	input wire logic signed [COMP_WIDTH-1:0] r_y,
	input wire logic signed [COMP_WIDTH-1:0] r_z,
	input wire logic signed [31:0]           scalar_result,
	input wire logic [1:0]                   status
);

	// A result waiting for transfer stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(r_w) && $stable(r_x) && $stable(r_y)
			&& $stable(r_z) && $stable(scalar_result) && $stable(status))
		else $error("result changed while stalled");

	// The identity replacement has a zero vector part and no scalar result.
	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_IDENT |-> r_x == 0 && r_y == 0 && r_z == 0
			&& scalar_result == 0)
		else $error("identity result with nonzero fields");

	// Only dot and length drive the scalar result, and they leave the quaternion zero.
	a_scalar_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && scalar_result != 0 |-> r_w == 0 && r_x == 0 && r_y == 0
			&& r_z == 0)
		else $error("scalar and quaternion result both nonzero");

	a_reset_empty: assert property (@(posedge clk) $rose(arst_n) |-> !out_valid)
		else $error("result offered right after reset");

endmodule

bind quaternion_arithmetic_unit qau_checker #(.COMP_WIDTH(COMP_WIDTH)) u_qau_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.r_w(r_w),
	.r_x(r_x),
	.r_y(r_y),
	.r_z(r_z),
	.scalar_result(scalar_result),
	.status(status)
);
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the quaternion arithmetic unit
// A table of directed requests runs first, then random requests. Every result
// transfer is compared field by field with a prediction made at the input
// transfer, with random input bursts and random output stalls.
// ----------------------------------------------------------------------------
module tb_top;
	import qau_pkg::*;

	localparam int FRAC = 12;
	localparam int CW = 16;
	localparam int N_RANDOM = 1300;
	localparam int LATENCY = CW + FRAC + 7;

	typedef struct {
		logic [3:0] op;
		logic signed [15:0] a[4];
		logic signed [15:0] b[4];
		logic signed [15:0] s;
	} request_t;

	typedef struct {
		logic signed [15:0] r[4];
		logic signed [31:0] sc;
		logic [1:0] st;
	} answer_t;

	typedef struct {
		request_t req;
		bit has_fixed;
		answer_t fixed;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] op = '0;
	logic signed [15:0] a_w = '0, a_x = '0, a_y = '0, a_z = '0;
	logic signed [15:0] b_w = '0, b_x = '0, b_y = '0, b_z = '0;
	logic signed [15:0] scale_factor = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] r_w, r_x, r_y, r_z;
	logic signed [31:0] scalar_result;
	logic [1:0] status;

	answer_t pending_answers[$];
	int errors = 0;

	always #4 clk = ~clk;

	quaternion_arithmetic_unit #(.FRAC_BITS(FRAC), .COMP_WIDTH(CW)) DUT (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.op(op), .a_w(a_w), .a_x(a_x), .a_y(a_y), .a_z(a_z),
		.b_w(b_w), .b_x(b_x), .b_y(b_y), .b_z(b_z), .scale_factor(scale_factor),
		.out_valid(out_valid), .out_ready(out_ready),
		.r_w(r_w), .r_x(r_x), .r_y(r_y), .r_z(r_z),
		.scalar_result(scalar_result), .status(status)
	);

	function automatic longint clamp(longint v, int w, inout bit flag);
		longint mx;
		longint mn;
		mx = (longint'(1) <<< (w - 1)) - 1;
		mn = -mx - 1;
		if (v > mx) begin
			flag = 1;
			return mx;
		end
		if (v < mn) begin
			flag = 1;
			return mn;
		end
		return v;
	endfunction

	// Products are exact in Q.24; one rounding (add half, floor) per sum.
	function automatic longint round_sum(longint p0, longint p1, longint p2, longint p3);
		longint t;
		t = p0 + p1 + p2 + p3 + (longint'(1) <<< (FRAC - 1));
		return t >>> FRAC;
	endfunction

	function automatic longint root_floor(longint unsigned x);
		longint unsigned r;
		longint unsigned bt;
		r = 0;
		bt = 64'd1 << 62;
		while (bt > x) bt >>= 2;
		while (bt != 0) begin
			if (x >= r + bt) begin
				x -= r + bt;
				r = (r >> 1) + bt;
			end else begin
				r >>= 1;
			end
			bt >>= 2;
		end
		return longint'(r);
	endfunction

	// Squares of 16-bit values never exceed 64 bits, so no clipping is needed.
	function automatic longint norm_length(longint q[4]);
		longint unsigned acc;
		acc = 0;
		for (int i = 0; i < 4; i++) acc += longint'(q[i] * q[i]);
		return root_floor(acc);
	endfunction

	function automatic void unit_quat(longint q[4], ref answer_t ans);
		longint len;
		longint m;
		longint v;
		bit flag;
		len = norm_length(q);
		flag = 0;
		if (len == 0) begin
			ans.r[0] = 16'(clamp(longint'(1) <<< FRAC, CW, flag));
			for (int i = 1; i < 4; i++) ans.r[i] = '0;
			ans.st = ST_IDENT;
			return;
		end
		for (int i = 0; i < 4; i++) begin
			m = (q[i] < 0) ? -q[i] : q[i];
			v = (2 * (m <<< FRAC) + len) / (2 * len);
			ans.r[i] = 16'(clamp((q[i] < 0) ? -v : v, CW, flag));
		end
		ans.st = flag ? ST_SAT : ST_OK;
	endfunction

	function automatic answer_t predict_quat_op(request_t rq);
		answer_t ans;
		longint a[4];
		longint b[4];
		longint s;
		longint len;
		bit flag;
		flag = 0;
		for (int i = 0; i < 4; i++) begin
			a[i] = rq.a[i];
			b[i] = rq.b[i];
			ans.r[i] = '0;
		end
		s = rq.s;
		ans.sc = '0;
		ans.st = ST_OK;
		case (rq.op)
			OP_ADD: for (int i = 0; i < 4; i++) ans.r[i] = 16'(clamp(a[i] + b[i], CW, flag));
			OP_SUB: for (int i = 0; i < 4; i++) ans.r[i] = 16'(clamp(a[i] - b[i], CW, flag));
			OP_MUL: begin
				ans.r[0] = 16'(clamp(round_sum(a[0]*b[0], -a[1]*b[1], -a[2]*b[2], -a[3]*b[3]),
					CW, flag));
				ans.r[1] = 16'(clamp(round_sum(a[0]*b[1], a[1]*b[0], a[2]*b[3], -a[3]*b[2]),
					CW, flag));
				ans.r[2] = 16'(clamp(round_sum(a[0]*b[2], -a[1]*b[3], a[2]*b[0], a[3]*b[1]),
					CW, flag));
				ans.r[3] = 16'(clamp(round_sum(a[0]*b[3], a[1]*b[2], -a[2]*b[1], a[3]*b[0]),
					CW, flag));
			end
			OP_CONJ: begin
				ans.r[0] = 16'(a[0]);
				for (int i = 1; i < 4; i++) ans.r[i] = 16'(clamp(-a[i], CW, flag));
			end
			OP_SCALE: for (int i = 0; i < 4; i++)
				ans.r[i] = 16'(clamp(round_sum(a[i] * s, 0, 0, 0), CW, flag));
			OP_DOT: ans.sc = 32'(clamp(round_sum(a[0]*b[0], a[1]*b[1], a[2]*b[2], a[3]*b[3]),
				32, flag));
			OP_LEN: begin
				len = norm_length(a);
				ans.sc = 32'(clamp(len, 32, flag));
			end
			OP_NORM: unit_quat(a, ans);
			OP_INV: begin
				for (int i = 1; i < 4; i++) a[i] = -a[i];
				unit_quat(a, ans);
			end
			default: ;
		endcase
		if (rq.op < OP_NORM) ans.st = flag ? ST_SAT : ST_OK;
		return ans;
	endfunction

	function automatic request_t quat_req(logic [3:0] o, int aw, int ax, int ay, int az,
		int bw, int bx, int by, int bz, int s);
		request_t rq;
		rq.op = o;
		rq.a[0] = 16'(aw); rq.a[1] = 16'(ax); rq.a[2] = 16'(ay); rq.a[3] = 16'(az);
		rq.b[0] = 16'(bw); rq.b[1] = 16'(bx); rq.b[2] = 16'(by); rq.b[3] = 16'(bz);
		rq.s = 16'(s);
		return rq;
	endfunction

	function automatic answer_t quat_ans(int w, int x, int y, int z, int sc, logic [1:0] st);
		answer_t ans;
		ans.r[0] = 16'(w); ans.r[1] = 16'(x); ans.r[2] = 16'(y); ans.r[3] = 16'(z);
		ans.sc = 32'(sc);
		ans.st = st;
		return ans;
	endfunction

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(0, 8192)) - 4096);
			3: return 16'(int'($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic request_t rand_req();
		request_t rq;
		rq.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
			: 4'($urandom_range(OP_ADD, OP_INV));
		for (int i = 0; i < 4; i++) begin
			rq.a[i] = rand_comp();
			rq.b[i] = rand_comp();
		end
		rq.s = rand_comp();
		// Now and then a zero quaternion, to reach the identity case.
		if ($urandom_range(0, 15) == 0)
			for (int i = 0; i < 4; i++) rq.a[i] = '0;
		return rq;
	endfunction

	int gap_left = 0;

	// Send one request; bursts of random length, sometimes separated by random gaps.
	// Valid stays high between back-to-back requests and drops only for a gap.
	task automatic send_request(request_t rq);
		if (gap_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
			gap_left = $urandom_range(1, 40);
		end
		gap_left--;
		op <= rq.op;
		a_w <= rq.a[0]; a_x <= rq.a[1]; a_y <= rq.a[2]; a_z <= rq.a[3];
		b_w <= rq.b[0]; b_x <= rq.b[1]; b_y <= rq.b[2]; b_z <= rq.b[3];
		scale_factor <= rq.s;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Receiver stalls in phases: free running, light and heavy back-pressure.
	always @(negedge clk) begin
		case (($time / 4000) % 3)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			default: out_ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	// Prediction at the input transfer keeps the expected order matched to the pipe.
	request_t seen_req;
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			seen_req.op = op;
			seen_req.a[0] = a_w; seen_req.a[1] = a_x; seen_req.a[2] = a_y; seen_req.a[3] = a_z;
			seen_req.b[0] = b_w; seen_req.b[1] = b_x; seen_req.b[2] = b_y; seen_req.b[3] = b_z;
			seen_req.s = scale_factor;
			pending_answers.push_back(predict_quat_op(seen_req));
		end
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_answers.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				want = pending_answers.pop_front();
				if (r_w !== want.r[0]) begin
					$error("r_w: expected %0d, got %0d", want.r[0], r_w);
					errors++;
				end
				if (r_x !== want.r[1]) begin
					$error("r_x: expected %0d, got %0d", want.r[1], r_x);
					errors++;
				end
				if (r_y !== want.r[2]) begin
					$error("r_y: expected %0d, got %0d", want.r[2], r_y);
					errors++;
				end
				if (r_z !== want.r[3]) begin
					$error("r_z: expected %0d, got %0d", want.r[3], r_z);
					errors++;
				end
				if (scalar_result !== want.sc) begin
					$error("scalar_result: expected %0d, got %0d", want.sc, scalar_result);
					errors++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, got %0d", want.st, status);
					errors++;
				end
			end
		end
	end

	initial begin
		row_t rows[$];
		row_t row;
		answer_t calc;
		rows = '{
			'{quat_req(OP_ADD, 32767, -32768, 1, -1, 1, -1, 0, 0, 0), 1,
				quat_ans(32767, -32768, 1, -1, 0, ST_SAT)},
			'{quat_req(OP_ADD, 4096, 0, 0, 0, 4096, 0, 0, 0, 0), 1,
				quat_ans(8192, 0, 0, 0, 0, ST_OK)},
			'{quat_req(OP_SUB, -32768, 32767, 0, 0, 1, -1, 0, 0, 0), 1,
				quat_ans(-32768, 32767, 0, 0, 0, ST_SAT)},
			'{quat_req(OP_MUL, 4096, 0, 0, 0, 0, 4096, 4096, 4096, 0), 1,
				quat_ans(0, 4096, 4096, 4096, 0, ST_OK)},
			'{quat_req(OP_MUL, 0, 4096, 0, 0, 0, 4096, 0, 0, 0), 1,
				quat_ans(-4096, 0, 0, 0, 0, ST_OK)},
			'{quat_req(OP_MUL, -32768, -32768, -32768, -32768, -32768, 32767, 32767, -32768,
				0), 0, quat_ans(0, 0, 0, 0, 0, ST_OK)},
			'{quat_req(OP_CONJ, 5, 1, -2, 3, 0, 0, 0, 0, 0), 1,
				quat_ans(5, -1, 2, -3, 0, ST_OK)},
			'{quat_req(OP_CONJ, -32768, -32768, 0, 32767, 0, 0, 0, 0, 0), 1,
				quat_ans(-32768, 32767, 0, -32767, 0, ST_SAT)},
			'{quat_req(OP_SCALE, 4096, -4096, 32767, -32768, 0, 0, 0, 0, 8192), 1,
				quat_ans(8192, -8192, 32767, -32768, 0, ST_SAT)},
			'{quat_req(OP_SCALE, 3, -3, 1, 0, 0, 0, 0, 0, -32768), 0,
				quat_ans(0, 0, 0, 0, 0, ST_OK)},
			'{quat_req(OP_DOT, 4096, 4096, 0, 0, 4096, -4096, 0, 0, 0), 1,
				quat_ans(0, 0, 0, 0, 0, ST_OK)},
			'{quat_req(OP_DOT, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
				0), 1, quat_ans(0, 0, 0, 0, 1048576, ST_OK)},
			'{quat_req(OP_LEN, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
				quat_ans(0, 0, 0, 0, 0, ST_OK)},
			'{quat_req(OP_LEN, -32768, -32768, -32768, -32768, 0, 0, 0, 0, 0), 1,
				quat_ans(0, 0, 0, 0, 65536, ST_OK)},
			'{quat_req(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
				quat_ans(4096, 0, 0, 0, 0, ST_IDENT)},
			'{quat_req(OP_NORM, 8192, 0, 0, 0, 0, 0, 0, 0, 0), 0,
				quat_ans(0, 0, 0, 0, 0, ST_OK)},
			'{quat_req(OP_NORM, 0, 0, 0, 1, 0, 0, 0, 0, 0), 0,
				quat_ans(0, 0, 0, 0, 0, ST_OK)},
			'{quat_req(OP_INV, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
				quat_ans(4096, 0, 0, 0, 0, ST_IDENT)},
			'{quat_req(OP_INV, 100, -32768, 32767, 7, 0, 0, 0, 0, 0), 0,
				quat_ans(0, 0, 0, 0, 0, ST_OK)},
			'{quat_req(4'd9, 1, 2, 3, 4, 5, 6, 7, 8, 9), 1,
				quat_ans(0, 0, 0, 0, 0, ST_OK)},
			'{quat_req(4'd15, -1, -1, -1, -1, -1, -1, -1, -1, -1), 1,
				quat_ans(0, 0, 0, 0, 0, ST_OK)}
		};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (rows[i]) begin
			row = rows[i];
			if (row.has_fixed) begin
				// Cross-check the hand-typed rows against the predictor itself.
				calc = predict_quat_op(row.req);
				if (calc != row.fixed) begin
					$error("row %0d: typed result disagrees with prediction", i);
					errors++;
				end
			end
			send_request(row.req);
		end
		for (int n = 0; n < N_RANDOM; n++) send_request(rand_req());
		in_valid <= 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (errors == 0 && pending_answers.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/qau_pkg.sv
hw/rtl/quaternion_arithmetic_unit.sv
hw/rtl/qau_checker.sv
test/tb_top.sv
